// ===== design/rau_pkg.sv =====
package rau_pkg;

  localparam int WIDTH = 32;
  localparam int DW = 2 * WIDTH;
  localparam int NW = DW + 1;
  localparam int MW = 32;
  localparam int CW = $clog2(NW + 1);

  typedef enum logic [1:0] {
    FUNC_ADD = 2'd0,
    FUNC_SUB = 2'd1,
    FUNC_MUL = 2'd2,
    FUNC_DIV = 2'd3
  } func_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_COMB,
    ST_MODLD,
    ST_DIVSTEP,
    ST_GCDCHK,
    ST_QDIV1,
    ST_QDIV2,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic mul1;
    logic mul2;
    logic comb;
    logic div_ld_mod;
    logic div_ld_gcd;
    logic div_ld_qn;
    logic div_ld_qd;
    logic div_step;
    logic gcd_swap;
    logic take_qn;
    logic take_qd;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic addsub;
    logic trivial;
    logic div_done;
    logic rem_zero;
  } sts_t;

endpackage

// ===== design/rau_datapath.sv =====
module rau_datapath (
  input  logic                   clk,
  input  rau_pkg::cmd_t          cmd,
  output rau_pkg::sts_t          sts,
  input  logic [1:0]             in_func,
  input  logic                   in_a_negative,
  input  logic [31:0]            in_a_num,
  input  logic [31:0]            in_a_den,
  input  logic                   in_b_negative,
  input  logic [31:0]            in_b_num,
  input  logic [31:0]            in_b_den,
  output logic                   res_negative,
  output logic [31:0]            res_num,
  output logic [31:0]            res_den,
  output logic                   res_overflow
);
  import rau_pkg::*;

  logic [1:0]      func_r;
  logic            as_r, bs_r;
  logic [WIDTH-1:0] an_r, ad_r, bn_r, bd_r;
  logic [DW-1:0]   p_r, q_r, den_r, g_r;
  logic [NW-1:0]   num_r, qn_r;
  logic            neg_r, triv_r;
  logic [NW-1:0]   dvd_r, quo_r;
  logic [DW:0]     rem_r;
  logic [DW-1:0]   dsr_r;
  logic [CW-1:0]   cnt_r;
  logic [DW-1:0]   gb_r;

  logic            out_neg_r, out_ovf_r;
  logic [31:0]     out_num_r, out_den_r;

  logic [DW-1:0]   m1, m2;
  logic            qs, as_w, bs_w;
  logic [DW:0]     rs;
  logic [DW:0]     trial;
  logic [DW-1:0]   mask;

  assign mask = {{(DW-WIDTH){1'b0}}, {WIDTH{1'b1}}};
  assign m1 = DW'(an_r) * DW'((func_r == FUNC_MUL) ? bn_r : bd_r);
  assign m2 = DW'(ad_r) * DW'((func_r == FUNC_DIV) ? bn_r : bd_r);
  assign as_w = as_r;
  assign bs_w = bs_r;
  assign qs = (q_r == '0) ? 1'b0 : ((func_r == FUNC_SUB) ? !bs_w : bs_w);
  assign rs = {rem_r[DW-1:0], dvd_r[NW-1]};
  assign trial = rs - {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= in_func;
      an_r <= in_a_num[WIDTH-1:0];
      ad_r <= in_a_den[WIDTH-1:0];
      bn_r <= in_b_num[WIDTH-1:0];
      bd_r <= in_b_den[WIDTH-1:0];
      as_r <= in_a_negative && (in_a_num[WIDTH-1:0] != '0);
      bs_r <= in_b_negative && (in_b_num[WIDTH-1:0] != '0);
    end
    if (cmd.mul1) p_r <= m1;
    if (cmd.mul2) begin
      q_r <= DW'(bn_r) * DW'(ad_r);
      den_r <= m2;
    end
    if (cmd.comb) begin
      if (func_r[1]) begin
        num_r <= NW'(p_r);
        neg_r <= (as_w != bs_w) && (p_r != '0);
        triv_r <= 1'b0;
      end else begin
        if (as_w == qs) begin
          num_r <= NW'(p_r) + NW'(q_r);
          neg_r <= as_w;
        end else if (p_r >= q_r) begin
          num_r <= NW'(p_r - q_r);
          neg_r <= as_w;
        end else begin
          num_r <= NW'(q_r - p_r);
          neg_r <= qs;
        end
        triv_r <= (den_r == '0) || ((as_w != qs) && (p_r == q_r))
                  || ((as_w == qs) && (p_r == '0) && (q_r == '0));
      end
    end
    if (cmd.div_ld_mod) begin
      dvd_r <= num_r; dsr_r <= den_r; rem_r <= '0; quo_r <= '0;
      cnt_r <= CW'(NW); gb_r <= den_r;
    end
    if (cmd.div_ld_gcd) begin
      dvd_r <= NW'(gb_r); dsr_r <= rem_r[DW-1:0]; gb_r <= rem_r[DW-1:0];
      rem_r <= '0; quo_r <= '0; cnt_r <= CW'(NW);
    end
    if (cmd.gcd_swap) g_r <= dsr_r;
    if (cmd.div_ld_qn) begin
      dvd_r <= num_r; dsr_r <= g_r; rem_r <= '0; quo_r <= '0; cnt_r <= CW'(NW);
    end
    if (cmd.div_ld_qd) begin
      dvd_r <= NW'(den_r); dsr_r <= g_r; rem_r <= '0; quo_r <= '0;
      cnt_r <= CW'(NW);
    end
    if (cmd.div_step) begin
      dvd_r <= {dvd_r[NW-2:0], 1'b0};
      cnt_r <= cnt_r - CW'(1);
      if (!trial[DW]) begin
        rem_r <= trial; quo_r <= {quo_r[NW-2:0], 1'b1};
      end else begin
        rem_r <= rs; quo_r <= {quo_r[NW-2:0], 1'b0};
      end
    end
    if (cmd.take_qn) qn_r <= quo_r;
    if (cmd.take_qd) den_r <= quo_r[DW-1:0];
    if (cmd.fin) begin
      if (func_r[1]) begin
        out_neg_r <= neg_r;
        out_num_r <= 32'(num_r[DW-1:0] & mask);
        out_den_r <= 32'(den_r & mask);
        out_ovf_r <= (num_r[DW-1:0] > mask) || (den_r > mask);
      end else if (triv_r) begin
        out_ovf_r <= 1'b0;
        out_den_r <= (den_r == '0 && num_r != '0) ? 32'd0 : 32'd1;
        out_num_r <= (num_r != '0) ? 32'd1 : 32'd0;
        out_neg_r <= (num_r != '0) ? neg_r : 1'b0;
      end else begin
        out_neg_r <= neg_r;
        out_num_r <= 32'(qn_r[DW-1:0] & mask);
        out_den_r <= 32'(den_r & mask);
        out_ovf_r <= qn_r[DW] || (qn_r[DW-1:0] > mask) || (den_r > mask);
      end
    end
  end

  assign sts.addsub = !func_r[1];
  assign sts.trivial = triv_r;
  assign sts.div_done = (cnt_r == '0);
  assign sts.rem_zero = (rem_r == '0);
  assign res_negative = out_neg_r;
  assign res_num = out_num_r;
  assign res_den = out_den_r;
  assign res_overflow = out_ovf_r;

endmodule

// ===== design/rau_ctrl.sv =====
module rau_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  rau_pkg::sts_t sts,
  output rau_pkg::cmd_t cmd
);
  import rau_pkg::*;

  state_t state_r, state_nxt;
  logic   ovalid_r, ovalid_nxt;
  logic   gcd_r, gcd_nxt;
  logic   qd_r, qd_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE; ovalid_r <= 1'b0; gcd_r <= 1'b0; qd_r <= 1'b0;
    end else begin
      state_r <= state_nxt; ovalid_r <= ovalid_nxt; gcd_r <= gcd_nxt; qd_r <= qd_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    gcd_nxt = gcd_r;
    qd_nxt = qd_r;
    unique case (state_r)
      ST_IDLE:    if (in_valid) state_nxt = ST_MUL1;
      ST_MUL1:    state_nxt = ST_MUL2;
      ST_MUL2:    state_nxt = ST_COMB;
      ST_COMB:    state_nxt = ST_MODLD;
      ST_MODLD: begin
        if (!sts.addsub || sts.trivial) state_nxt = ST_DONE;
        else begin state_nxt = ST_DIVSTEP; gcd_nxt = 1'b0; qd_nxt = 1'b0; end
      end
      ST_DIVSTEP: begin
        if (sts.div_done) begin
          if (!gcd_r) state_nxt = ST_GCDCHK;
          else if (!qd_r) state_nxt = ST_QDIV2;
          else state_nxt = ST_DONE;
        end
      end
      ST_GCDCHK:  state_nxt = sts.rem_zero ? ST_QDIV1 : ST_DIVSTEP;
      ST_QDIV1:   begin state_nxt = ST_DIVSTEP; gcd_nxt = 1'b1; end
      ST_QDIV2:   begin state_nxt = ST_DIVSTEP; qd_nxt = 1'b1; end
      ST_DONE:    if (!ovalid_r || out_ready) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      ST_IDLE:    cmd.load = in_valid;
      ST_MUL1:    cmd.mul1 = 1'b1;
      ST_MUL2:    cmd.mul2 = 1'b1;
      ST_COMB:    cmd.comb = 1'b1;
      ST_MODLD:   cmd.div_ld_mod = 1'b1;
      ST_DIVSTEP: begin
        cmd.div_step = !sts.div_done;
        cmd.take_qn = sts.div_done && gcd_r && !qd_r;
        cmd.take_qd = sts.div_done && gcd_r && qd_r;
      end
      ST_GCDCHK: begin
        cmd.gcd_swap = 1'b1;
        cmd.div_ld_gcd = !sts.rem_zero;
      end
      ST_QDIV1:   cmd.div_ld_qn = 1'b1;
      ST_QDIV2:   cmd.div_ld_qd = 1'b1;
      ST_DONE:    cmd.fin = !ovalid_r || out_ready;
      default:    cmd = '0;
    endcase
  end

  assign in_ready = (state_r == ST_IDLE);
  assign ovalid_nxt = cmd.fin ? 1'b1 : (out_ready ? 1'b0 : ovalid_r);
  assign out_valid = ovalid_r;

endmodule

// ===== design/rational_arithmetic_unit_top.sv =====
// Rational arithmetic unit: add, subtract, multiply or divide two
// sign-magnitude fractions.
// Input channel in_valid/in_ready carries func and the two operands.
// Output channel out_valid/out_ready carries res_negative, res_num,
// res_den and overflow; one result item per input item, in order.
// Multiply and divide, and add or subtract with a zero sum or a zero
// denominator, pass MUL1, MUL2, COMB and MODLD and go straight to DONE.
// Other add and subtract items reduce by a gcd formed with a shared
// bit-serial restoring divider of 65 steps; each Euclid remainder takes
// one divider pass and a GCDCHK state, and the 64-bit cross-product
// numerator and the denominator are then each divided by the gcd.
// One item is in work at a time; in_ready is high only when idle, so the
// next accept comes at the earliest in the cycle after the result is written.
// The output register holds a result while out_ready is low; the next
// item may be accepted and worked, and waits at its end for the slot.
// Synchronous active-low reset clears the controller and out_valid.
module rational_arithmetic_unit_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_func,
  input  logic        in_a_negative,
  input  logic [31:0] in_a_num,
  input  logic [31:0] in_a_den,
  input  logic        in_b_negative,
  input  logic [31:0] in_b_num,
  input  logic [31:0] in_b_den,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_res_negative,
  output logic [31:0] out_res_num,
  output logic [31:0] out_res_den,
  output logic        out_overflow
);
  import rau_pkg::*;

  cmd_t cmd;
  sts_t sts;

  rau_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .sts(sts), .cmd(cmd)
  );

  rau_datapath u_dp (
    .clk(clk), .cmd(cmd), .sts(sts), .in_func(in_func),
    .in_a_negative(in_a_negative), .in_a_num(in_a_num), .in_a_den(in_a_den),
    .in_b_negative(in_b_negative), .in_b_num(in_b_num), .in_b_den(in_b_den),
    .res_negative(out_res_negative), .res_num(out_res_num),
    .res_den(out_res_den), .res_overflow(out_overflow)
  );

`ifndef SYNTH
  a_one_op: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("accepted while busy");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid && $stable(out_res_num))
    else $error("result dropped");
`endif

endmodule

// ===== tb/tb_rational_arithmetic_unit_top.sv =====
`timescale 1ns / 100ps

module tb_rational_arithmetic_unit_top;
  import rau_pkg::*;

  localparam int CYCLE_LIMIT = 60_000_000;

  typedef struct {
    logic        neg;
    logic [31:0] num;
    logic [31:0] den;
    logic        ovf;
  } fraction_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_func;
  logic        in_a_negative;
  logic [31:0] in_a_num;
  logic [31:0] in_a_den;
  logic        in_b_negative;
  logic [31:0] in_b_num;
  logic [31:0] in_b_den;
  logic        out_valid;
  logic        out_ready;
  logic        out_res_negative;
  logic [31:0] out_res_num;
  logic [31:0] out_res_den;
  logic        out_overflow;

  fraction_t   pending_results[$];
  int          mismatches;
  int          cycles;
  bit          hold_off;

  rational_arithmetic_unit_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_func(in_func),
    .in_a_negative(in_a_negative), .in_a_num(in_a_num), .in_a_den(in_a_den),
    .in_b_negative(in_b_negative), .in_b_num(in_b_num), .in_b_den(in_b_den),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_res_negative(out_res_negative), .out_res_num(out_res_num),
    .out_res_den(out_res_den), .out_overflow(out_overflow)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic logic [63:0] gcd_of(logic [63:0] x, logic [63:0] y);
    logic [63:0] t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  function automatic fraction_t compute_fraction(func_t op, logic sa, logic [31:0] an,
                                                 logic [31:0] ad, logic sb,
                                                 logic [31:0] bn, logic [31:0] bd);
    fraction_t   r;
    logic        a_neg, b_neg, q_neg, neg, big;
    logic [64:0] p, q, sum, quo;
    logic [63:0] num, den, g;
    a_neg = sa && an != 0;
    b_neg = sb && bn != 0;
    neg = 1'b0;
    big = 1'b0;
    if (op == FUNC_ADD || op == FUNC_SUB) begin
      p = 65'(an) * 65'(bd);
      q = 65'(bn) * 65'(ad);
      den = 64'(ad) * 64'(bd);
      q_neg = (op == FUNC_SUB) ? !b_neg : b_neg;
      if (q == 0) q_neg = 1'b0;
      if (a_neg == q_neg) begin
        sum = p + q;
        neg = a_neg;
      end else if (p >= q) begin
        sum = p - q;
        neg = a_neg;
      end else begin
        sum = q - p;
        neg = q_neg;
      end
      if (sum == 0) begin
        neg = 1'b0;
        num = 0;
        den = 1;
      end else if (den == 0) begin
        num = 1;
      end else begin
        g = gcd_of(den, 64'(sum % 65'(den)));
        quo = sum / 65'(g);
        big = quo[64];
        num = quo[63:0];
        den = den / g;
      end
    end else begin
      if (op == FUNC_MUL) begin
        num = 64'(an) * 64'(bn);
        den = 64'(ad) * 64'(bd);
      end else begin
        num = 64'(an) * 64'(bd);
        den = 64'(ad) * 64'(bn);
      end
      neg = (a_neg != b_neg) && num != 0;
    end
    r.neg = neg;
    r.num = num[31:0];
    r.den = den[31:0];
    r.ovf = big || num[63:32] != 0 || den[63:32] != 0;
    return r;
  endfunction

  task automatic send_item(func_t op, logic sa, logic [31:0] an, logic [31:0] ad,
                           logic sb, logic [31:0] bn, logic [31:0] bd);
    int gap;
    gap = $urandom_range(0, 4);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= op;
    in_a_negative <= sa;
    in_a_num <= an;
    in_a_den <= ad;
    in_b_negative <= sb;
    in_b_num <= bn;
    in_b_den <= bd;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(compute_fraction(op, sa, an, ad, sb, bn, bd));
  endtask

  function automatic logic [31:0] rand_mag();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 3);
      1: return $urandom_range(1, 255);
      2: return $urandom_range(1, 65535);
      3: return 32'hFFFF_FFFF - $urandom_range(0, 3);
      default: return $urandom;
    endcase
  endfunction

  task automatic test_directed();
    func_t op;
    for (int f = 0; f < 4; f++) begin
      op = func_t'(f);
      send_item(op, 1'b0, 32'd1, 32'd2, 1'b0, 32'd1, 32'd3);
      send_item(op, 1'b1, 32'd0, 32'd5, 1'b1, 32'd3, 32'd4);
      send_item(op, 1'b1, 32'd7, 32'd3, 1'b0, 32'd7, 32'd3);
      send_item(op, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 32'd1);
      send_item(op, 1'b1, 32'd5, 32'd0, 1'b0, 32'd0, 32'd0);
    end
    send_item(FUNC_ADD, 1'b0, 32'hFFFF_FFFF, 32'd1, 1'b0, 32'hFFFF_FFFF, 32'd1);
    send_item(FUNC_SUB, 1'b1, 32'hFFFF_FFFF, 32'd1, 1'b0, 32'hFFFF_FFFF, 32'd1);
    send_item(FUNC_SUB, 1'b0, 32'd3, 32'd4, 1'b0, 32'd3, 32'd4);
    send_item(FUNC_DIV, 1'b0, 32'd3, 32'd4, 1'b1, 32'd0, 32'd9);
    send_item(FUNC_MUL, 1'b1, 32'h8000_0000, 32'd2, 1'b1, 32'd2, 32'h8000_0000);
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++)
      send_item(func_t'($urandom_range(0, 3)), 1'($urandom), rand_mag(), rand_mag(),
                1'($urandom), rand_mag(), rand_mag());
  endtask

  task automatic test_output_stall();
    hold_off = 1'b1;
    fork
      begin
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 6; i++)
        send_item(func_t'(i[0] ? FUNC_DIV : FUNC_MUL), 1'($urandom), rand_mag(),
                  rand_mag(), 1'($urandom), rand_mag(), rand_mag());
    join
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= !hold_off && ($urandom_range(0, 4) != 0 || $urandom_range(0, 1) == 0);
    end
  end

  always @(posedge clk) begin
    fraction_t exp_r;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item at cycle %0d", cycles);
      end else begin
        exp_r = pending_results.pop_front();
        if (out_res_negative !== exp_r.neg || out_res_num !== exp_r.num ||
            out_res_den !== exp_r.den || out_overflow !== exp_r.ovf) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected neg=%0b %0d/%0d ovf=%0b, got neg=%0b %0d/%0d ovf=%0b",
                     exp_r.neg, exp_r.num, exp_r.den, exp_r.ovf, out_res_negative,
                     out_res_num, out_res_den, out_overflow);
        end
      end
    end
  end

  initial begin
    cycles = 0;
    mismatches = 0;
    hold_off = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_func = FUNC_ADD;
    in_a_negative = 1'b0;
    in_a_num = '0;
    in_a_den = '0;
    in_b_negative = 1'b0;
    in_b_num = '0;
    in_b_den = '0;
    out_ready = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_output_stall();
    test_random(2000);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
